### rtl/plm_pkg.sv
// Shared constants, types and codes for the ping liveness monitor.
package plm_pkg;

  // Table geometry
  localparam int NUM_PEERS       = 16;
  localparam int MAX_OUTSTANDING = 8;

  localparam int PEER_W     = 4;
  localparam int WORD_W     = 32;
  localparam int PEER_IDX_W = $clog2(NUM_PEERS);
  localparam int SLOT_W     = $clog2(MAX_OUTSTANDING);
  localparam int RING_AW    = PEER_IDX_W + SLOT_W;
  localparam int RING_DEPTH = NUM_PEERS * MAX_OUTSTANDING;

  localparam logic [WORD_W-1:0] PING_GRACE_RST = 32'd15000;

  // Request actions
  typedef enum logic [1:0] {
    ACT_PING  = 2'd0,
    ACT_PONG  = 2'd1,
    ACT_RESET = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  // Write request into the send-time ring
  typedef struct packed {
    logic               en;
    logic [RING_AW-1:0] addr;
    logic [WORD_W-1:0]  data;
  } ring_wr_t;

endpackage

### rtl/plm_send_ring.sv
// Send-time ring memory with registered read and write-to-read forwarding.
module plm_send_ring (
  input  logic                      clk,
  input  plm_pkg::ring_wr_t         wr,
  input  logic                      rd_en,
  input  logic [plm_pkg::RING_AW-1:0] rd_addr,
  output logic [plm_pkg::WORD_W-1:0]  rd_data
);
  import plm_pkg::*;

  logic [WORD_W-1:0] mem [RING_DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  // Write the slot of a new ping
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read, forwarding a same-cycle write to the same slot
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_data_r <= wr.data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/ping_liveness_monitor.sv
// Per-peer ping/pong liveness table: top level with request and result stages.
//
// Accepts one request per clock cycle unless in_stall is high, and returns
// exactly one result per request, in order, via the request register and
// then the result register. The request is registered together with a read
// of the send-time ring (addressed by peer and pong sequence), so the
// per-peer table update, pong match and lag check happen combinationally
// between the request and result registers. Back-to-back requests to the
// same peer see each other's updates. ping_grace may be rewritten only while
// no request is in flight. The ring needs no clearing after reset.
module ping_liveness_monitor (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [plm_pkg::WORD_W-1:0]   cfg_wdata,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_action,
  input  logic [plm_pkg::PEER_W-1:0]   in_peer,
  input  logic [plm_pkg::WORD_W-1:0]   in_pong_seq,
  input  logic [plm_pkg::WORD_W-1:0]   in_now_time,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_peer_known,
  output logic                         out_pong_matched,
  output logic                         out_lagging,
  output logic [plm_pkg::WORD_W-1:0]   out_ping_seq
);
  import plm_pkg::*;

  // Configuration register
  logic [WORD_W-1:0] ping_grace_r;

  // Request stage
  logic              s1_valid_r;
  action_t           s1_action_r;
  logic [PEER_W-1:0] s1_peer_r;
  logic [WORD_W-1:0] s1_pong_seq_r;
  logic [WORD_W-1:0] s1_now_r;

  // Result stage
  logic              out_valid_r;
  logic              out_known_r;
  logic              out_matched_r;
  logic              out_lagging_r;
  logic [WORD_W-1:0] out_seq_r;

  // Per-peer tables
  logic              entry_valid_r [NUM_PEERS];
  logic [WORD_W-1:0] next_seq_r    [NUM_PEERS];
  logic [WORD_W-1:0] oldest_seq_r  [NUM_PEERS];
  logic [WORD_W-1:0] last_ack_r    [NUM_PEERS];

  // Handshake
  logic in_fire;
  logic s1_go;

  // Processing signals
  logic [PEER_IDX_W-1:0] p_idx;
  logic                  in_range;
  logic                  known;
  logic [WORD_W-1:0]     cur_next;
  logic [WORD_W-1:0]     cur_oldest;
  logic [WORD_W-1:0]     cur_ack;
  logic [WORD_W-1:0]     pong_off;
  logic [WORD_W-1:0]     pong_cnt;
  logic [WORD_W-1:0]     ring_rd_data;
  ring_wr_t              ring_wr;

  logic                  tbl_we;
  logic                  valid_nxt;
  logic [WORD_W-1:0]     next_seq_nxt;
  logic [WORD_W-1:0]     oldest_seq_nxt;
  logic [WORD_W-1:0]     last_ack_nxt;
  logic                  matched_nxt;
  logic                  lagging_nxt;
  logic [WORD_W-1:0]     seq_nxt;

  // Advance the request stage when the result register is free
  assign s1_go    = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // Configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ping_grace_r <= PING_GRACE_RST;
    end else if (cfg_we) begin
      ping_grace_r <= cfg_wdata;
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r   <= action_t'(in_action);
      s1_peer_r     <= in_peer;
      s1_pong_seq_r <= in_pong_seq;
      s1_now_r      <= in_now_time;
    end
  end

  // Send-time ring, read at acceptance so data lines up with the request stage
  plm_send_ring u_ring (
    .clk     (clk),
    .wr      (ring_wr),
    .rd_en   (in_fire),
    .rd_addr ({in_peer[PEER_IDX_W-1:0], in_pong_seq[SLOT_W-1:0]}),
    .rd_data (ring_rd_data)
  );

  // Look up the addressed peer
  assign p_idx      = s1_peer_r[PEER_IDX_W-1:0];
  assign in_range   = (32'(s1_peer_r) < 32'(NUM_PEERS));
  assign known      = in_range && entry_valid_r[p_idx];
  assign cur_next   = known ? next_seq_r[p_idx]   : '0;
  assign cur_oldest = known ? oldest_seq_r[p_idx] : '0;
  assign cur_ack    = known ? last_ack_r[p_idx]   : s1_now_r;
  assign pong_off   = s1_pong_seq_r - cur_oldest;
  assign pong_cnt   = cur_next - cur_oldest;

  // Work out the table update and the result
  always_comb begin
    tbl_we         = 1'b0;
    valid_nxt      = known;
    next_seq_nxt   = cur_next;
    oldest_seq_nxt = cur_oldest;
    last_ack_nxt   = cur_ack;
    matched_nxt    = 1'b0;
    lagging_nxt    = 1'b0;
    seq_nxt        = '0;
    ring_wr.en     = 1'b0;
    ring_wr.addr   = {p_idx, cur_next[SLOT_W-1:0]};
    ring_wr.data   = s1_now_r;
    if (s1_valid_r && in_range) begin
      unique case (s1_action_r)
        ACT_PING: begin
          tbl_we       = 1'b1;
          valid_nxt    = 1'b1;
          next_seq_nxt = cur_next + 32'd1;
          seq_nxt      = cur_next;
          ring_wr.en   = s1_go;
          // Drop the oldest ping when the ring is full
          if (pong_cnt >= 32'(MAX_OUTSTANDING)) begin
            oldest_seq_nxt = cur_oldest + 32'd1;
          end
        end
        ACT_PONG: begin
          if (known && (pong_off < pong_cnt)) begin
            tbl_we         = 1'b1;
            last_ack_nxt   = ring_rd_data;
            oldest_seq_nxt = s1_pong_seq_r;
            matched_nxt    = 1'b1;
          end
        end
        ACT_RESET: begin
          tbl_we    = 1'b1;
          valid_nxt = 1'b0;
        end
        ACT_QUERY: begin
          lagging_nxt = known && ((s1_now_r - cur_ack) > ping_grace_r);
        end
        default: begin
          tbl_we = 1'b0;
        end
      endcase
    end
  end

  // Peer valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PEERS; i++) begin
        entry_valid_r[i] <= 1'b0;
      end
    end else if (s1_go && tbl_we) begin
      entry_valid_r[p_idx] <= valid_nxt;
    end
  end

  // Peer sequence and ack tables
  always_ff @(posedge clk) begin
    if (s1_go && tbl_we) begin
      next_seq_r[p_idx]   <= next_seq_nxt;
      oldest_seq_r[p_idx] <= oldest_seq_nxt;
      last_ack_r[p_idx]   <= last_ack_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_known_r   <= known;
      out_matched_r <= matched_nxt;
      out_lagging_r <= lagging_nxt;
      out_seq_r     <= seq_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_peer_known   = out_known_r;
  assign out_pong_matched = out_matched_r;
  assign out_lagging      = out_lagging_r;
  assign out_ping_seq     = out_seq_r;

  // A stall on requests comes only from a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("request stall without a pending result");

  // Outstanding count of a known peer never exceeds its MAX_OUTSTANDING ring slots
  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && known) |-> (pong_cnt <= 32'(MAX_OUTSTANDING)))
    else $error("outstanding pings exceed ring depth");

  // A processed ping leaves its peer open
  a_ping_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && in_range && (s1_action_r == ACT_PING)) |=> entry_valid_r[$past(p_idx)])
    else $error("ping did not open peer entry");

  // Pong and query results never carry a ping sequence, nor set both match and lag
  a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_matched_r || out_lagging_r)) |->
      ((out_seq_r == '0) && !(out_matched_r && out_lagging_r)))
    else $error("result flags of different actions mixed");

endmodule
